FILE: rtl/vsrt_pkg.sv
// ----------------------------------------------------------------------------
// vsrt_pkg
// Shared types and constants of the vertex scale, rotate and translate block.
// ----------------------------------------------------------------------------
`default_nettype none

package vsrt_pkg;

  localparam int COORD_W      = 32;
  localparam int SCALED_W     = 48;
  localparam int TRIG_W       = 16;
  localparam int TRIG_DEPTH   = 1024;
  localparam int CORDIC_STEPS = 30;
  // angle quantize (4 stages), cordic iterations, rounding stage
  localparam int TRIG_LAT     = CORDIC_STEPS + 5;

  localparam logic ACT_POINT = 1'b0;
  localparam logic ACT_BOX   = 1'b1;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] scale_x;
    logic signed [COORD_W-1:0] scale_y;
    logic signed [COORD_W-1:0] rotation;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      shape_end;
  } vsrt_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vert_x;
    logic signed [COORD_W-1:0] vert_y;
    logic [1:0]                corner;
    logic                      last;
  } vsrt_out_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

endpackage

`default_nettype wire

FILE: rtl/vsrt_trig.sv
// ----------------------------------------------------------------------------
// vsrt_trig
// Pipelined sine and cosine of an angle in degrees: modulo-360 quantize to
// the table step, quadrant fold, one CORDIC iteration per stage, Q1.15 round.
// ----------------------------------------------------------------------------
`default_nettype none

module vsrt_trig (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [vsrt_pkg::COORD_W-1:0]   rotation_i,
  output vsrt_pkg::trig_t                       trig_o
);

  localparam int TURN_Q16   = 23592960;
  localparam int STEP_DIV   = TURN_Q16 / vsrt_pkg::TRIG_DEPTH;
  localparam int STEP_ODD   = 45;
  localparam int STEP_SHIFT = $clog2(STEP_DIV / STEP_ODD);
  localparam int HALF_STEP  = STEP_DIV / 2;
  localparam int DEPTH_W    = $clog2(vsrt_pkg::TRIG_DEPTH);
  localparam int OFFSET     = STEP_ODD * (1 << 24);
  localparam int U_W        = 30;
  localparam int RECIP      = 95443717;
  localparam int PROD_W     = 57;
  localparam int Q_W        = PROD_W - 32;
  localparam int REM_W      = 7;
  localparam int ANG_W      = 32;
  localparam int CW         = 34;
  localparam int NS         = vsrt_pkg::CORDIC_STEPS;
  localparam int TW         = vsrt_pkg::TRIG_W;

  localparam logic signed [CW-1:0] GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] ATAN [NS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81,
    34'sd41,        34'sd20,        34'sd10,        34'sd5,
    34'sd3,         34'sd1
  };

  function automatic logic signed [TW-1:0] to_q15(input logic signed [CW-1:0] v,
                                                  input logic flip);
    logic signed [CW-1:0] r;
    logic signed [CW-16:0] t;
    logic signed [TW:0] c;
    r = v + CW'(16384);
    t = r[CW-1:15];
    if (t > 19'sd32767) begin
      c = 17'sd32767;
    end else if (t < -19'sd32768) begin
      c = -17'sd32768;
    end else begin
      c = t[TW:0];
    end
    if (flip) begin
      c = -c;
      if (c > 17'sd32767) begin
        c = 17'sd32767;
      end
    end
    return c[TW-1:0];
  endfunction

  // angle quantize
  logic signed [32:0]      ang_sum;
  logic signed [32:0]      ang_shr;
  logic [32:0]             u_full;
  logic [U_W-1:0]          u_d, u_q, u2_q;
  logic [PROD_W-1:0]       prod_d, prod_q;
  logic [Q_W-1:0]          q0;
  logic [30:0]             rem_full;
  logic [REM_W-1:0]        rem_q;
  logic [DEPTH_W-1:0]      q0_q;
  logic [DEPTH_W-1:0]      step;
  logic [ANG_W-1:0]        ang;
  logic                    flip_d, flip0_q;
  logic signed [CW-1:0]    z0_d, z0_q;

  assign ang_sum = {rotation_i[vsrt_pkg::COORD_W-1], rotation_i} + 33'(HALF_STEP);
  assign ang_shr = ang_sum >>> STEP_SHIFT;
  assign u_full  = ang_shr + 33'(OFFSET);
  assign u_d     = u_full[U_W-1:0];
  assign prod_d  = PROD_W'(u_q) * PROD_W'(RECIP);
  assign q0      = prod_q[PROD_W-1:32];
  assign rem_full = 31'(u2_q) - 31'(q0) * 31'(STEP_ODD);
  assign step    = q0_q + DEPTH_W'(rem_q >= REM_W'(STEP_ODD));
  assign ang     = {step, {(ANG_W-DEPTH_W){1'b0}}};
  assign flip_d  = ang[ANG_W-1] ^ ang[ANG_W-2];
  assign z0_d    = CW'($signed({ang[ANG_W-1] ^ flip_d, ang[ANG_W-2:0]}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q     <= u_d;
      prod_q  <= prod_d;
      u2_q    <= u_q;
      q0_q    <= q0[DEPTH_W-1:0];
      rem_q   <= rem_full[REM_W-1:0];
      z0_q    <= z0_d;
      flip0_q <= flip_d;
    end
  end

  // cordic iterations
  logic signed [CW-1:0] cx_in [NS];
  logic signed [CW-1:0] cy_in [NS];
  logic signed [CW-1:0] cz_in [NS];
  logic                 cf_in [NS];
  logic signed [CW-1:0] cx_q [NS];
  logic signed [CW-1:0] cy_q [NS];
  logic signed [CW-1:0] cz_q [NS];
  logic                 cf_q [NS];

  always_comb begin
    cx_in[0] = GAIN;
    cy_in[0] = '0;
    cz_in[0] = z0_q;
    cf_in[0] = flip0_q;
    for (int k = 1; k < NS; k++) begin
      cx_in[k] = cx_q[k-1];
      cy_in[k] = cy_q[k-1];
      cz_in[k] = cz_q[k-1];
      cf_in[k] = cf_q[k-1];
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    assign xs = cx_in[i] >>> i;
    assign ys = cy_in[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cz_in[i][CW-1]) begin
          cx_q[i] <= cx_in[i] - ys;
          cy_q[i] <= cy_in[i] + xs;
          cz_q[i] <= cz_in[i] - ATAN[i];
        end else begin
          cx_q[i] <= cx_in[i] + ys;
          cy_q[i] <= cy_in[i] - xs;
          cz_q[i] <= cz_in[i] + ATAN[i];
        end
        cf_q[i] <= cf_in[i];
      end
    end
  end

  // round to q1.15
  vsrt_pkg::trig_t trig_d, trig_q;

  assign trig_d.cos_v = to_q15(cx_q[NS-1], cf_q[NS-1]);
  assign trig_d.sin_v = to_q15(cy_q[NS-1], cf_q[NS-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q <= trig_d;
    end
  end

  assign trig_o = trig_q;

endmodule

`default_nettype wire

FILE: rtl/vertex_scale_rotate_translate.sv
// ----------------------------------------------------------------------------
// vertex_scale_rotate_translate
// 2D vertex transform: scale, rotate, translate with saturated Q16.16 output.
// ----------------------------------------------------------------------------
// One vertex request leaves per clock unless the output is stalled. A point
// request yields one vertex, and point requests can be taken back to back;
// a box request yields its four corners (top-left, top-right, bottom-right,
// bottom-left), and the next request is taken only with its last corner.
// Sine and cosine for each vertex come from the 30-stage CORDIC. The whole
// pipeline holds while a finished vertex is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_scale_rotate_translate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vsrt_pkg::vsrt_in_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vsrt_pkg::vsrt_out_t out_req_o
);

  localparam int CWD       = vsrt_pkg::COORD_W;
  localparam int SW        = vsrt_pkg::SCALED_W;
  localparam int TW        = vsrt_pkg::TRIG_W;
  localparam int PW        = 2 * CWD;
  localparam int RPW       = SW + TW;
  localparam int SUM_W     = RPW + 1;
  localparam int SH_W      = SUM_W - 15;
  localparam int FIN_W     = SH_W + 1;
  localparam int MID_N     = vsrt_pkg::TRIG_LAT - 2;
  localparam int OUT_STAGE = vsrt_pkg::TRIG_LAT + 3;

  typedef struct packed {
    logic [CWD-1:0]        mag_lx;
    logic [CWD-1:0]        mag_kx;
    logic [CWD-1:0]        mag_ly;
    logic [CWD-1:0]        mag_ky;
    logic                  neg_x;
    logic                  neg_y;
    logic                  point;
    logic [1:0]            corner;
    logic                  last;
    logic signed [CWD-1:0] px;
    logic signed [CWD-1:0] py;
  } s1_t;

  typedef struct packed {
    logic [PW-1:0]         prod_x;
    logic [PW-1:0]         prod_y;
    logic                  neg_x;
    logic                  neg_y;
    logic                  point;
    logic [1:0]            corner;
    logic                  last;
    logic signed [CWD-1:0] px;
    logic signed [CWD-1:0] py;
  } s2_t;

  typedef struct packed {
    logic signed [SW-1:0]  sx;
    logic signed [SW-1:0]  sy;
    logic [1:0]            corner;
    logic                  last;
    logic signed [CWD-1:0] px;
    logic signed [CWD-1:0] py;
  } mid_t;

  typedef struct packed {
    logic signed [RPW-1:0] p_xc;
    logic signed [RPW-1:0] p_ys;
    logic signed [RPW-1:0] p_xs;
    logic signed [RPW-1:0] p_yc;
    logic [1:0]            corner;
    logic                  last;
    logic signed [CWD-1:0] px;
    logic signed [CWD-1:0] py;
  } r1_t;

  typedef struct packed {
    logic signed [SH_W-1:0] rx;
    logic signed [SH_W-1:0] ry;
    logic [1:0]             corner;
    logic                   last;
    logic signed [CWD-1:0]  px;
    logic signed [CWD-1:0]  py;
  } r2_t;

  function automatic logic [CWD-1:0] mag(input logic signed [CWD-1:0] v);
    return v[CWD-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic signed [SW-1:0] scale_round(input logic [PW-1:0] p,
                                                       input logic point,
                                                       input logic neg);
    logic [SW-1:0] q;
    if (point) begin
      q = p[PW-1:16] + SW'(p[15]);
    end else begin
      q = {1'b0, p[PW-1:17]} + SW'(p[16]);
    end
    return neg ? -q : q;
  endfunction

  function automatic logic signed [CWD-1:0] sat_coord(input logic signed [FIN_W-1:0] v);
    if (v > $signed({{(FIN_W-CWD+1){1'b0}}, {(CWD-1){1'b1}}})) begin
      return {1'b0, {(CWD-1){1'b1}}};
    end else if (v < $signed({{(FIN_W-CWD+1){1'b1}}, {(CWD-1){1'b0}}})) begin
      return {1'b1, {(CWD-1){1'b0}}};
    end
    return v[CWD-1:0];
  endfunction

  // pipeline enable and valid chain
  logic                 en;
  logic [OUT_STAGE:1]   vld_q;

  assign en = !(vld_q[OUT_STAGE] && out_stall_i);

  // box expander
  logic                 busy_d, busy_q;
  logic [1:0]           cnt_d, cnt_q;
  vsrt_pkg::vsrt_in_t   item_q;
  logic                 is_point;
  logic                 slot_last;
  logic                 accept;
  logic                 flip_x;
  logic                 flip_y;

  assign is_point  = (item_q.action == vsrt_pkg::ACT_POINT);
  assign slot_last = is_point || (cnt_q == vsrt_pkg::CORNER_BL);
  assign in_stall_o = !(en && (!busy_q || slot_last));
  assign accept    = in_valid_i && !in_stall_o;
  assign flip_x    = !is_point &&
                     ((cnt_q == vsrt_pkg::CORNER_TL) || (cnt_q == vsrt_pkg::CORNER_BL));
  assign flip_y    = !is_point &&
                     ((cnt_q == vsrt_pkg::CORNER_TL) || (cnt_q == vsrt_pkg::CORNER_TR));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = vsrt_pkg::CORNER_TL;
    end else if (en && busy_q) begin
      if (slot_last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= vsrt_pkg::CORNER_TL;
      vld_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (en) begin
        vld_q <= {vld_q[OUT_STAGE-1:1], busy_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_req_i;
    end
  end

  // sine and cosine
  vsrt_pkg::trig_t trig;

  vsrt_trig u_trig (
    .clk_i      (clk_i),
    .en_i       (en),
    .rotation_i (item_q.rotation),
    .trig_o     (trig)
  );

  // magnitudes, products, scaled values
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  mid_t mid_d;
  mid_t mid_q [MID_N];

  always_comb begin
    s1_d.mag_lx = mag(item_q.point_x);
    s1_d.mag_kx = mag(item_q.scale_x);
    s1_d.mag_ly = mag(item_q.point_y);
    s1_d.mag_ky = mag(item_q.scale_y);
    s1_d.neg_x  = item_q.point_x[CWD-1] ^ item_q.scale_x[CWD-1] ^ flip_x;
    s1_d.neg_y  = item_q.point_y[CWD-1] ^ item_q.scale_y[CWD-1] ^ flip_y;
    s1_d.point  = is_point;
    s1_d.corner = is_point ? vsrt_pkg::CORNER_TL : cnt_q;
    s1_d.last   = is_point ? item_q.shape_end : (cnt_q == vsrt_pkg::CORNER_BL);
    s1_d.px     = item_q.pos_x;
    s1_d.py     = item_q.pos_y;
  end

  always_comb begin
    s2_d.prod_x = PW'(s1_q.mag_lx) * PW'(s1_q.mag_kx);
    s2_d.prod_y = PW'(s1_q.mag_ly) * PW'(s1_q.mag_ky);
    s2_d.neg_x  = s1_q.neg_x;
    s2_d.neg_y  = s1_q.neg_y;
    s2_d.point  = s1_q.point;
    s2_d.corner = s1_q.corner;
    s2_d.last   = s1_q.last;
    s2_d.px     = s1_q.px;
    s2_d.py     = s1_q.py;
  end

  always_comb begin
    mid_d.sx     = scale_round(s2_q.prod_x, s2_q.point, s2_q.neg_x);
    mid_d.sy     = scale_round(s2_q.prod_y, s2_q.point, s2_q.neg_y);
    mid_d.corner = s2_q.corner;
    mid_d.last   = s2_q.last;
    mid_d.px     = s2_q.px;
    mid_d.py     = s2_q.py;
  end

  // rotation products, round, translate, saturate
  r1_t  r1_d, r1_q;
  r2_t  r2_d, r2_q;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [FIN_W-1:0] fin_x;
  logic signed [FIN_W-1:0] fin_y;
  vsrt_pkg::vsrt_out_t out_d, out_q;

  always_comb begin
    r1_d.p_xc   = RPW'(mid_q[MID_N-1].sx) * RPW'(trig.cos_v);
    r1_d.p_ys   = RPW'(mid_q[MID_N-1].sy) * RPW'(trig.sin_v);
    r1_d.p_xs   = RPW'(mid_q[MID_N-1].sx) * RPW'(trig.sin_v);
    r1_d.p_yc   = RPW'(mid_q[MID_N-1].sy) * RPW'(trig.cos_v);
    r1_d.corner = mid_q[MID_N-1].corner;
    r1_d.last   = mid_q[MID_N-1].last;
    r1_d.px     = mid_q[MID_N-1].px;
    r1_d.py     = mid_q[MID_N-1].py;
  end

  assign sum_x = SUM_W'(r1_q.p_xc) - SUM_W'(r1_q.p_ys) + SUM_W'(16384);
  assign sum_y = SUM_W'(r1_q.p_xs) + SUM_W'(r1_q.p_yc) + SUM_W'(16384);

  always_comb begin
    r2_d.rx     = sum_x[SUM_W-1:15];
    r2_d.ry     = sum_y[SUM_W-1:15];
    r2_d.corner = r1_q.corner;
    r2_d.last   = r1_q.last;
    r2_d.px     = r1_q.px;
    r2_d.py     = r1_q.py;
  end

  assign fin_x = FIN_W'(r2_q.rx) + FIN_W'(r2_q.px);
  assign fin_y = FIN_W'(r2_q.ry) + FIN_W'(r2_q.py);

  always_comb begin
    out_d.vert_x = sat_coord(fin_x);
    out_d.vert_y = sat_coord(fin_y);
    out_d.corner = r2_q.corner;
    out_d.last   = r2_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      mid_q[0] <= mid_d;
      for (int k = 1; k < MID_N; k++) begin
        mid_q[k] <= mid_q[k-1];
      end
      r1_q     <= r1_d;
      r2_q     <= r2_d;
      out_q    <= out_d;
    end
  end

  assign out_valid_o = vld_q[OUT_STAGE];
  assign out_req_o   = out_q;

  // checks
  a_box_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.corner == vsrt_pkg::CORNER_BL) |-> out_req_o.last)
    else $error("bottom-left corner without last");

  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && (cnt_q == vsrt_pkg::CORNER_TL))
    else $error("accepted request not loaded into expander");

  a_corner_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && en && !slot_last |=> busy_q && (cnt_q == $past(cnt_q) + 2'd1))
    else $error("box corner sequence broken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid chain moved while stalled");

endmodule

`default_nettype wire
